### hdl/clm_pkg.sv
// Shared types and constants for the cursor linked list manager.
// No dependencies; every other file of the block imports this package.
package clm_pkg;

    localparam int ACT_W  = 3;
    localparam int IDX_W  = 7;
    localparam int DATA_W = 16;
    localparam int ST_W   = 2;

    localparam logic [ACT_W-1:0] ACT_READ   = 3'd0;
    localparam logic [ACT_W-1:0] ACT_WRITE  = 3'd1;
    localparam logic [ACT_W-1:0] ACT_INSERT = 3'd2;
    localparam logic [ACT_W-1:0] ACT_DELETE = 3'd3;
    localparam logic [ACT_W-1:0] ACT_HEAD   = 3'd4;
    localparam logic [ACT_W-1:0] ACT_SUCC   = 3'd5;

    localparam logic [ST_W-1:0] ST_OK     = 2'd0;
    localparam logic [ST_W-1:0] ST_END    = 2'd1;
    localparam logic [ST_W-1:0] ST_FULL   = 2'd2;
    localparam logic [ST_W-1:0] ST_ABSENT = 2'd3;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_READ_WAIT,
        S_SUCC_WAIT,
        S_WALK_INS,
        S_ALLOC,
        S_INS_LINK,
        S_WALK_DEL,
        S_DEL_FIX,
        S_DEL_FREE,
        S_RESP
    } state_t;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_CAPTURE,
        OP_VAL_READ,
        OP_VAL_WRITE,
        OP_SET_DATA,
        OP_SET_HEAD,
        OP_ABSENT,
        OP_FULL,
        OP_LINK_READ_X,
        OP_SUCC_DONE,
        OP_WALK_START,
        OP_WALK_STEP,
        OP_INS_HIT,
        OP_FREE_READ,
        OP_ALLOC,
        OP_LINK_X,
        OP_DEL_HIT,
        OP_DEL_FIX,
        OP_DEL_FREE,
        OP_RESULT
    } dp_op_t;

    typedef struct packed {
        logic [ACT_W-1:0] act;
        logic             good;
        logic             head_zero;
        logic             free_zero;
        logic             x_is_head;
        logic             cur_hit;
        logic             lnk_hit;
        logic             lnk_zero;
        logic             out_free;
    } dp_stat_t;

endpackage

### hdl/clm_req_if.sv
// Request channel of the list manager: valid/ready plus one request item.
// Depends on clm_pkg for field widths.
interface clm_req_if import clm_pkg::*; ();

    logic              valid;
    logic              ready;
    logic [ACT_W-1:0]  action;
    logic [IDX_W-1:0]  node_index;
    logic [DATA_W-1:0] data_in;

    modport source (output valid, output action, output node_index, output data_in,
                    input ready);
    modport sink   (input valid, input action, input node_index, input data_in,
                    output ready);

endinterface

### hdl/clm_rsp_if.sv
// Response channel of the list manager: valid/ready plus one result item.
// Depends on clm_pkg for field widths.
interface clm_rsp_if import clm_pkg::*; ();

    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] data_out;
    logic [IDX_W-1:0]  index_out;
    logic              list_empty;
    logic [ST_W-1:0]   status;

    modport source (output valid, output data_out, output index_out, output list_empty,
                    output status, input ready);
    modport sink   (input valid, input data_out, input index_out, input list_empty,
                    input status, output ready);

endinterface

### hdl/clm_ctrl.sv
// Controller of the list manager: sequences one request through the datapath.
// Depends on clm_pkg (state_t, dp_op_t, dp_stat_t, action codes).
module clm_ctrl import clm_pkg::*; (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     req_valid,
    output logic     req_ready,
    input  dp_stat_t stat,
    output dp_op_t   op
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                unique case (stat.act)
                    ACT_READ:   state_next = stat.good ? S_READ_WAIT : S_RESP;
                    ACT_INSERT:
                    begin
                        if (stat.head_zero)
                        begin
                            state_next = stat.free_zero ? S_RESP : S_ALLOC;
                        end
                        else
                        begin
                            state_next = stat.good ? S_WALK_INS : S_RESP;
                        end
                    end
                    ACT_DELETE:
                    begin
                        if (!stat.good || stat.head_zero)
                        begin
                            state_next = S_RESP;
                        end
                        else
                        begin
                            state_next = stat.x_is_head ? S_DEL_FIX : S_WALK_DEL;
                        end
                    end
                    ACT_SUCC:   state_next = stat.good ? S_SUCC_WAIT : S_RESP;
                    default:    state_next = S_RESP;
                endcase
            end
            S_READ_WAIT: state_next = S_RESP;
            S_SUCC_WAIT: state_next = S_RESP;
            S_WALK_INS:
            begin
                if (stat.cur_hit)
                begin
                    state_next = stat.free_zero ? S_RESP : S_ALLOC;
                end
                else if (stat.lnk_zero)
                begin
                    state_next = S_RESP;
                end
            end
            S_ALLOC:     state_next = stat.head_zero ? S_RESP : S_INS_LINK;
            S_INS_LINK:  state_next = S_RESP;
            S_WALK_DEL:
            begin
                if (stat.lnk_hit)
                begin
                    state_next = S_DEL_FIX;
                end
                else if (stat.lnk_zero)
                begin
                    state_next = S_RESP;
                end
            end
            S_DEL_FIX:   state_next = S_DEL_FREE;
            S_DEL_FREE:  state_next = S_RESP;
            S_RESP:
            begin
                if (stat.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:     state_next = S_IDLE;
        endcase
    end

    // datapath command
    always_comb
    begin
        op        = OP_NONE;
        req_ready = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    op = OP_CAPTURE;
                end
            end
            S_DISPATCH:
            begin
                unique case (stat.act)
                    ACT_READ:  op = stat.good ? OP_VAL_READ : OP_ABSENT;
                    ACT_WRITE: op = stat.good ? OP_VAL_WRITE : OP_ABSENT;
                    ACT_INSERT:
                    begin
                        if (stat.head_zero)
                        begin
                            op = stat.free_zero ? OP_FULL : OP_FREE_READ;
                        end
                        else
                        begin
                            op = stat.good ? OP_WALK_START : OP_ABSENT;
                        end
                    end
                    ACT_DELETE:
                    begin
                        if (!stat.good || stat.head_zero)
                        begin
                            op = OP_ABSENT;
                        end
                        else
                        begin
                            op = stat.x_is_head ? OP_LINK_READ_X : OP_WALK_START;
                        end
                    end
                    ACT_HEAD:  op = OP_SET_HEAD;
                    ACT_SUCC:  op = stat.good ? OP_LINK_READ_X : OP_ABSENT;
                    default:   op = OP_NONE;
                endcase
            end
            S_READ_WAIT: op = OP_SET_DATA;
            S_SUCC_WAIT: op = OP_SUCC_DONE;
            S_WALK_INS:
            begin
                if (stat.cur_hit)
                begin
                    op = stat.free_zero ? OP_FULL : OP_INS_HIT;
                end
                else
                begin
                    op = stat.lnk_zero ? OP_ABSENT : OP_WALK_STEP;
                end
            end
            S_ALLOC:     op = OP_ALLOC;
            S_INS_LINK:  op = OP_LINK_X;
            S_WALK_DEL:
            begin
                if (stat.lnk_hit)
                begin
                    op = OP_DEL_HIT;
                end
                else
                begin
                    op = stat.lnk_zero ? OP_ABSENT : OP_WALK_STEP;
                end
            end
            S_DEL_FIX:   op = OP_DEL_FIX;
            S_DEL_FREE:  op = OP_DEL_FREE;
            S_RESP:      op = stat.out_free ? OP_RESULT : OP_NONE;
            default:     op = OP_NONE;
        endcase
    end

endmodule

### hdl/clm_dp.sv
// Datapath of the list manager: link and value tables, list pointers, result register.
// Depends on clm_pkg and clm_rsp_if; driven one command per cycle by clm_ctrl.
module clm_dp import clm_pkg::*; #(
    parameter int ENTRIES     = 128,
    parameter int VALUE_WIDTH = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  dp_op_t            op,
    input  logic [ACT_W-1:0]  req_action,
    input  logic [IDX_W-1:0]  req_node_index,
    input  logic [DATA_W-1:0] req_data_in,
    output dp_stat_t          stat,
    clm_rsp_if.source         rsp
);

    localparam int IW = $clog2(ENTRIES);

    typedef logic [IW-1:0]          node_t;
    typedef logic [VALUE_WIDTH-1:0] value_t;

    node_t  link_mem  [ENTRIES];
    value_t value_mem [ENTRIES];

    logic [ACT_W-1:0]  act_reg,  act_next;
    logic [IDX_W-1:0]  idx_reg,  idx_next;
    logic [DATA_W-1:0] data_reg, data_next;
    node_t             cur_reg,  cur_next;
    node_t             save_reg, save_next;
    node_t             pred_reg, pred_next;
    logic [DATA_W-1:0] res_data_reg,   res_data_next;
    node_t             res_index_reg,  res_index_next;
    logic [ST_W-1:0]   res_status_reg, res_status_next;
    node_t             head_reg, head_next;
    node_t             free_reg, free_next;
    node_t             hwm_reg,  hwm_next;
    logic              out_valid_reg,  out_valid_next;
    logic [DATA_W-1:0] out_data_reg,   out_data_next;
    logic [IDX_W-1:0]  out_index_reg,  out_index_next;
    logic              out_empty_reg,  out_empty_next;
    logic [ST_W-1:0]   out_status_reg, out_status_next;

    node_t  link_rd_reg;
    node_t  init_reg;
    logic   fresh_reg;
    value_t val_rd_reg;

    logic   link_we, link_re, val_we, val_re;
    node_t  link_wa, link_wd, link_ra, val_wa;
    value_t val_in;
    node_t  x_node, lnk, init_link;
    logic [IW:0] init_sum;
    logic   out_free;

    assign x_node   = IW'(idx_reg);
    assign val_in   = VALUE_WIDTH'(data_reg);
    // never-allocated entries read as their reset link, computed here rather than stored
    assign lnk      = fresh_reg ? init_reg : link_rd_reg;
    assign out_free = !out_valid_reg || rsp.ready;

    assign init_sum  = (IW+1)'(link_ra) + (IW+1)'(1);
    assign init_link = (init_sum < (IW+1)'(ENTRIES)) ? IW'(init_sum) : '0;

    assign stat.act       = act_reg;
    assign stat.good      = (idx_reg != '0) && (32'(idx_reg) < ENTRIES);
    assign stat.head_zero = (head_reg == '0);
    assign stat.free_zero = (free_reg == '0);
    assign stat.x_is_head = (head_reg == x_node);
    assign stat.cur_hit   = (cur_reg == x_node);
    assign stat.lnk_hit   = (lnk == x_node);
    assign stat.lnk_zero  = (lnk == '0);
    assign stat.out_free  = out_free;

    always_comb
    begin
        act_next        = act_reg;
        idx_next        = idx_reg;
        data_next       = data_reg;
        cur_next        = cur_reg;
        save_next       = save_reg;
        pred_next       = pred_reg;
        res_data_next   = res_data_reg;
        res_index_next  = res_index_reg;
        res_status_next = res_status_reg;
        head_next       = head_reg;
        free_next       = free_reg;
        hwm_next        = hwm_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        out_data_next   = out_data_reg;
        out_index_next  = out_index_reg;
        out_empty_next  = out_empty_reg;
        out_status_next = out_status_reg;
        link_we = 1'b0;
        link_wa = x_node;
        link_wd = free_reg;
        link_re = 1'b0;
        link_ra = x_node;
        val_we  = 1'b0;
        val_wa  = x_node;
        val_re  = 1'b0;
        unique case (op)
            OP_CAPTURE:
            begin
                act_next        = req_action;
                idx_next        = req_node_index;
                data_next       = req_data_in;
                save_next       = '0;
                pred_next       = '0;
                res_data_next   = '0;
                res_index_next  = '0;
                res_status_next = ST_OK;
            end
            OP_VAL_READ:    val_re = 1'b1;
            OP_VAL_WRITE:   val_we = 1'b1;
            OP_SET_DATA:    res_data_next = DATA_W'(val_rd_reg);
            OP_SET_HEAD:    res_index_next = head_reg;
            OP_ABSENT:      res_status_next = ST_ABSENT;
            OP_FULL:        res_status_next = ST_FULL;
            OP_LINK_READ_X: link_re = 1'b1;
            OP_SUCC_DONE:
            begin
                if (lnk == '0)
                begin
                    res_status_next = ST_END;
                end
                else
                begin
                    res_index_next = lnk;
                end
            end
            OP_WALK_START:
            begin
                cur_next = head_reg;
                link_re  = 1'b1;
                link_ra  = head_reg;
            end
            OP_WALK_STEP:
            begin
                cur_next = lnk;
                link_re  = 1'b1;
                link_ra  = lnk;
            end
            OP_INS_HIT:
            begin
                save_next = lnk;
                link_re   = 1'b1;
                link_ra   = free_reg;
            end
            OP_FREE_READ:
            begin
                link_re = 1'b1;
                link_ra = free_reg;
            end
            OP_ALLOC:
            begin
                link_we        = 1'b1;
                link_wa        = free_reg;
                link_wd        = save_reg;
                val_we         = 1'b1;
                val_wa         = free_reg;
                free_next      = lnk;
                res_index_next = free_reg;
                if (head_reg == '0)
                begin
                    head_next = free_reg;
                end
                if (free_reg > hwm_reg)
                begin
                    hwm_next = free_reg;
                end
            end
            OP_LINK_X:
            begin
                link_we = 1'b1;
                link_wd = res_index_reg;
            end
            OP_DEL_HIT:
            begin
                pred_next = cur_reg;
                link_re   = 1'b1;
            end
            OP_DEL_FIX:
            begin
                if (pred_reg == '0)
                begin
                    head_next = lnk;
                end
                else
                begin
                    link_we = 1'b1;
                    link_wa = pred_reg;
                    link_wd = lnk;
                end
            end
            OP_DEL_FREE:
            begin
                link_we   = 1'b1;
                free_next = x_node;
            end
            OP_RESULT:
            begin
                out_valid_next  = 1'b1;
                out_data_next   = res_data_reg;
                out_index_next  = IDX_W'(res_index_reg);
                out_empty_next  = (head_reg == '0);
                out_status_next = res_status_reg;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            free_reg      <= IW'(1);
            hwm_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            head_reg      <= head_next;
            free_reg      <= free_next;
            hwm_reg       <= hwm_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        act_reg        <= act_next;
        idx_reg        <= idx_next;
        data_reg       <= data_next;
        cur_reg        <= cur_next;
        save_reg       <= save_next;
        pred_reg       <= pred_next;
        res_data_reg   <= res_data_next;
        res_index_reg  <= res_index_next;
        res_status_reg <= res_status_next;
        out_data_reg   <= out_data_next;
        out_index_reg  <= out_index_next;
        out_empty_reg  <= out_empty_next;
        out_status_reg <= out_status_next;
    end

    always_ff @(posedge clk)
    begin
        if (link_we)
        begin
            link_mem[link_wa] <= link_wd;
        end
        if (link_re)
        begin
            link_rd_reg <= link_mem[link_ra];
            fresh_reg   <= (link_ra > hwm_reg);
            init_reg    <= init_link;
        end
    end

    always_ff @(posedge clk)
    begin
        if (val_we)
        begin
            value_mem[val_wa] <= val_in;
        end
        if (val_re)
        begin
            val_rd_reg <= value_mem[x_node];
        end
    end

    assign rsp.valid      = out_valid_reg;
    assign rsp.data_out   = out_data_reg;
    assign rsp.index_out  = out_index_reg;
    assign rsp.list_empty = out_empty_reg;
    assign rsp.status     = out_status_reg;

`ifndef SYNTHESIS
    a_head_free_apart: assert property (@(posedge clk) disable iff (!rst_n)
        !(head_reg == free_reg && head_reg != '0))
        else $error("list head and free head point to the same node");

    a_alloc_nonfull: assert property (@(posedge clk) disable iff (!rst_n)
        op == OP_ALLOC |-> free_reg != '0)
        else $error("allocation from an empty free list");

    a_hwm_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> hwm_reg >= $past(hwm_reg))
        else $error("allocation mark moved backward");

    a_result_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        op == OP_RESULT |-> out_free)
        else $error("result loaded over an item not yet taken");
`endif

endmodule

### hdl/cursor_linked_list_manager_unit.sv
// Cursor linked list manager: one singly linked list in a fixed node table.
//
// Channels: req (sink) carries action, node_index and data_in; rsp (source)
// carries data_out, index_out, list_empty and status. Each accepted item
// gives exactly one result item, in order.
// Path of an accepted request: it is captured, then dispatched on its action. A
// write or get head completes at dispatch; a read or get successor waits for its
// table read; an insert into a non-empty list or a delete of a non-head node first
// walks the list from the head. An insert then allocates from the free list and,
// after a node, links the new node in; a delete fixes the predecessor link or the
// head and then frees the node. Requests refused go straight to the result.
// The walk follows one link per cycle through the single read port of the
// link table; requests are handled one at a time, so the next item is taken the
// cycle after the previous result is loaded.
// A new item is accepted while the previous result waits in the output
// register; a stalled rsp holds its item and the next result waits for it.
// Reset empties the list and threads entries 1 and up onto the free list at once;
// entries never allocated read as their reset link, so no clearing pass runs.
// Depends on clm_pkg, clm_req_if, clm_rsp_if, clm_ctrl and clm_dp.
module cursor_linked_list_manager_unit import clm_pkg::*; #(
    parameter int ENTRIES     = 128,
    parameter int VALUE_WIDTH = 16
) (
    input  logic      clk,
    input  logic      rst_n,
    clm_req_if.sink   req,
    clm_rsp_if.source rsp
);

    dp_op_t   op;
    dp_stat_t stat;
    logic     ctrl_ready;

    assign req.ready = ctrl_ready;

    clm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (ctrl_ready),
        .stat      (stat),
        .op        (op)
    );

    clm_dp #(
        .ENTRIES     (ENTRIES),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .op             (op),
        .req_action     (req.action),
        .req_node_index (req.node_index),
        .req_data_in    (req.data_in),
        .stat           (stat),
        .rsp            (rsp)
    );

endmodule
